// ===== rtl/hotp_totp_code_checker_unit_assert.svh =====
// Assertion macros for the checker file of the code checker unit.
`ifndef HOTP_TOTP_CODE_CHECKER_UNIT_ASSERT_SVH
`define HOTP_TOTP_CODE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define HOTP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define HOTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hotp_pkg.sv =====
// Package of the code checker: types and fixed constants.
`default_nettype none
package hotp_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TDIV,
        S_TWAIT,
        S_HGO,
        S_HWAIT,
        S_MGO,
        S_MWAIT,
        S_DONE
    } t_state;

    localparam logic [1:0] REG_KEY_FIRST = 2'd0;
    localparam logic [1:0] REG_KEY_LAST  = 2'd1;
    localparam logic [1:0] REG_KEY_LEN   = 2'd2;

    localparam logic [19:0] CODE_MODULUS = 20'd1000000;

    // ceil(2^39 / 15625): exact quotient of any 25-bit value by 15625 after >> 39.
    localparam logic [25:0] RECIP_15625  = 26'd35184373;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5C;

    localparam logic [159:0] H_INIT =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Message lengths in bits of the inner and outer HMAC messages.
    localparam logic [63:0] INNER_BITS = 64'd576;
    localparam logic [63:0] OUTER_BITS = 64'd672;

endpackage
`default_nettype wire

// ===== rtl/hotp_totp_code_checker_unit.sv =====
// Top level of the HOTP/TOTP six-digit code checker.
// Usage:
//   Write the key over the config channel while the block is idle: index 0
//   takes key bytes 0..7, index 1 bytes 8..9, index 2 the key length.
//   The config channel is always ready; unknown indexes are dropped.
//   Present a request on the slave stream: tuser selects HOTP (0) or TOTP (1),
//   tdata carries the moving value and the candidate code.
//   One result per request leaves on the master stream: the computed code and
//   a match flag.
// Sequence:
//   One request at a time. A HOTP request runs four SHA-1 compressions
//   (each: launch, 80 rounds, chaining add, done), then the reciprocal modulo,
//   then the load of the output register. TOTP first divides by 30 with a
//   shift-and-fold loop. s_axis_tready is high only when idle, so a new
//   request is taken only once the last result is in the output register.
// Reset:
//   Synchronous, active low; clears the key registers, the sequencer and the
//   output valid.
// Stall:
//   A result waits in the output register while the receiver holds tready
//   low; the sequencer holds in its final state until that register frees.
`default_nettype none
module hotp_totp_code_checker_unit
    import hotp_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [87:0] i_s_axis_tdata,  // [63:0] moving_value, [83:64] candidate_code
    input  wire logic        i_s_axis_tuser,  // [0] action
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata   // [0] code_valid, [20:1] expected_code
);

    t_state r_state, n_state;

    logic [63:0]  r_key_first;
    logic [15:0]  r_key_last;
    logic [3:0]   r_key_len;

    logic         r_act;
    logic [63:0]  r_factor;
    logic [19:0]  r_cand;
    logic [1:0]   r_blk;
    logic [159:0] r_chain;
    logic [159:0] r_ihash;

    logic         r_ovalid;
    logic [23:0]  r_odata;

    logic         in_acc;
    logic         out_free;
    logic         sha_start, div_start;
    logic         sha_done, div_done;
    logic [159:0] sha_h;
    logic [63:0]  div_quot;
    logic [19:0]  div_rem;

    logic [3:0]   klen;
    logic [79:0]  key80;
    logic [511:0] key_blk;
    logic [511:0] blk;
    logic [159:0] h_in;
    logic [3:0]   off;
    logic [7:0]   base;
    logic [31:0]  bin;
    logic [63:0]  div_dvd;
    logic         div_tdiv;

    assign o_cfg_ready     = 1'b1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // Config registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_first <= '0;
            r_key_last  <= '0;
            r_key_len   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY_FIRST: r_key_first <= i_cfg_data;
                REG_KEY_LAST:  r_key_last  <= i_cfg_data[15:0];
                REG_KEY_LEN:   r_key_len   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Mask key bytes past the saturated length, then pad to a 64-byte block.
    always_comb begin
        klen  = (r_key_len > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : r_key_len;
        key80 = {r_key_first, r_key_last};
        for (int i = 0; i < 10; i++) begin
            if (4'(i) >= klen) begin
                key80[79 - 8*i -: 8] = 8'h00;
            end
        end
        key_blk = {key80, 432'b0};
    end

    // Block and chaining value for each of the four compressions.
    always_comb begin
        unique case (r_blk)
            2'd0:    blk = key_blk ^ {64{IPAD}};
            2'd1:    blk = {r_factor, 8'h80, 376'b0, INNER_BITS};
            2'd2:    blk = key_blk ^ {64{OPAD}};
            default: blk = {r_ihash, 8'h80, 280'b0, OUTER_BITS};
        endcase
        h_in = r_blk[0] ? r_chain : H_INIT;
    end

    // Dynamic truncation of the final digest and choice of the divider input.
    always_comb begin
        off  = r_chain[3:0];
        base = 8'd128 - {1'b0, off, 3'b000};
        bin  = r_chain[base +: 32];
        bin[31] = 1'b0;
        div_tdiv = (r_state == S_TDIV);
        div_dvd  = div_tdiv ? r_factor : {32'b0, bin};
    end

    hotp_sha1_core u_sha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sha_start),
        .i_block (blk),
        .i_h     (h_in),
        .o_done  (sha_done),
        .o_h     (sha_h)
    );

    hotp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_tdiv  (div_tdiv),
        .i_value (div_dvd),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = i_s_axis_tuser ? S_TDIV : S_HGO;
            S_TDIV:  n_state = S_TWAIT;
            S_TWAIT: if (div_done) n_state = S_HGO;
            S_HGO:   n_state = S_HWAIT;
            S_HWAIT: if (sha_done) n_state = (r_blk == 2'd3) ? S_MGO : S_HGO;
            S_MGO:   n_state = S_MWAIT;
            S_MWAIT: if (div_done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer: unit launches.
    always_comb begin
        sha_start = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            S_TDIV:  div_start = 1'b1;
            S_MGO:   div_start = 1'b1;
            S_HGO:   sha_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act    <= i_s_axis_tuser;
            r_factor <= i_s_axis_tdata[63:0];
            r_cand   <= i_s_axis_tdata[83:64];
            r_blk    <= 2'd0;
        end
        if (r_state == S_TWAIT && div_done && r_act) begin
            r_factor <= div_quot;
        end
        if (r_state == S_HWAIT && sha_done) begin
            r_chain <= sha_h;
            r_blk   <= r_blk + 2'd1;
            if (r_blk == 2'd1) begin
                r_ihash <= sha_h;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_odata <= {3'b000, div_rem, (r_cand == div_rem)};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hotp_sha1_core.sv =====
// SHA-1 compression engine: one round per cycle, then the chaining add.
`default_nettype none
module hotp_sha1_core
    import hotp_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [511:0] i_block,
    input  wire logic [159:0] i_h,
    output logic              o_done,
    output logic [159:0]      o_h
);

    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  r_w [16];
    logic [159:0] r_h;
    logic [6:0]   r_cnt;
    logic         r_run;
    logic         r_add;
    logic         r_done;
    logic [159:0] r_hout;

    logic [31:0] f, k, tmp, w_x, w_new;

    always_comb begin
        if (r_cnt < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = K0;
        end else if (r_cnt < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = K1;
        end else if (r_cnt < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K3;
        end
        tmp   = {r_a[26:0], r_a[31:27]} + f + r_e + k + r_w[0];
        w_x   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {w_x[30:0], w_x[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_add  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_add;
            r_add  <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd79) begin
                    r_run <= 1'b0;
                    r_add <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h <= i_h;
            {r_a, r_b, r_c, r_d, r_e} <= i_h;
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511 - 32*i -: 32];
            end
        end else if (r_run) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= tmp;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end
        if (r_add) begin
            r_hout <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                       r_h[63:32] + r_d, r_h[31:0] + r_e};
        end
    end

    assign o_done = r_done;
    assign o_h    = r_hout;

endmodule
`default_nettype wire

// ===== rtl/hotp_divider.sv =====
// Constant divider: shift-and-fold division by 30 and reciprocal reduction modulo one million.
`default_nettype none
module hotp_divider
    import hotp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_tdiv,     // 1: divide by 30, 0: reduce modulo one million
    input  wire logic [63:0] i_value,
    output logic             o_done,
    output logic [63:0]      o_quot,
    output logic [19:0]      o_rem
);

    logic        r_run;
    logic        r_tdiv;
    logic        r_ph;
    logic        r_done;
    logic [62:0] r_r;
    logic [63:0] r_q;
    logic [30:0] r_x;
    logic [50:0] r_prod;
    logic [19:0] r_rem;

    logic [62:0] digit;
    logic        fold;
    logic [30:0] qm;
    logic [30:0] rem_w;

    // Fold step for /15: r = 16*t + low gives r - 15*t = t + low.
    always_comb begin
        digit = {4'b0, r_r[62:4]};
        fold  = (r_r[62:4] != '0);
        qm    = {19'b0, r_prod[50:39]} * {11'b0, CODE_MODULUS};
        rem_w = r_x - qm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_tdiv ? !fold : r_ph) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_tdiv <= i_tdiv;
            r_ph   <= 1'b0;
            r_r    <= i_value[63:1];
            r_q    <= '0;
            r_x    <= i_value[30:0];
        end else if (r_run) begin
            r_ph <= 1'b1;
            if (r_tdiv) begin
                if (fold) begin
                    r_q <= r_q + {1'b0, digit};
                    r_r <= digit + {59'b0, r_r[3:0]};
                end else if (r_r[3:0] == 4'hF) begin
                    r_q <= r_q + 64'd1;
                    r_r <= '0;
                end
            end else if (!r_ph) begin
                // x / 1000000 = (x >> 6) / 15625
                r_prod <= {26'b0, r_x[30:6]} * {25'b0, RECIP_15625};
            end else begin
                r_rem <= rem_w[19:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== rtl/hotp_sva.sv =====
// Port-level checker of the code checker unit and its bind.
`default_nettype none
`include "hotp_totp_code_checker_unit_assert.svh"
module hotp_sva (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata
);

    `HOTP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result dropped or changed under stall")
    `HOTP_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "request taken while busy")
    `HOTP_ASSERT_NOW(a_code_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[20:1] < 20'd1000000, "code out of range")

endmodule

bind hotp_totp_code_checker_unit hotp_sva u_hotp_sva (.*);
`default_nettype wire
